FILE: rtl/core/dvte_pkg.sv
// shared types, constants and byte-selection helpers of the trace encoder
package dvte_pkg;

  localparam int unsigned TS_W   = 64;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 4;

  // upper bounds of the one, two and four byte value forms
  localparam logic [TS_W-1:0] LIMIT_ONE  = 64'h0000_0000_0000_003F;
  localparam logic [TS_W-1:0] LIMIT_TWO  = 64'h0000_0000_0000_3FFF;
  localparam logic [TS_W-1:0] LIMIT_FOUR = 64'h0000_0000_FFFF_FFFF;

  // prefix and tag bytes
  localparam logic [1:0]        PFX_ONE   = 2'b00;
  localparam logic [1:0]        PFX_TWO   = 2'b01;
  localparam logic [BYTE_W-1:0] TAG_FOUR  = 8'h80;
  localparam logic [BYTE_W-1:0] TAG_EIGHT = 8'hC0;

  // encoded length class of one value
  typedef enum logic [1:0] {
    SZ_ONE,
    SZ_TWO,
    SZ_FOUR,
    SZ_EIGHT
  } size_e;

  // one classified event waiting for serialization
  typedef struct packed {
    logic [TS_W-1:0] delta;
    logic [TS_W-1:0] duration;
    size_e           delta_sz;
    size_e           dur_sz;
  } evt_entry_t;

  // length class of a value
  function automatic size_e classify(input logic [TS_W-1:0] v);
    size_e sz;
    priority if (v <= LIMIT_ONE) begin
      sz = SZ_ONE;
    end else if (v <= LIMIT_TWO) begin
      sz = SZ_TWO;
    end else if (v <= LIMIT_FOUR) begin
      sz = SZ_FOUR;
    end else begin
      sz = SZ_EIGHT;
    end
    return sz;
  endfunction

  // index of the final byte of a value's encoding
  function automatic logic [IDX_W-1:0] last_index(input size_e sz);
    logic [IDX_W-1:0] n;
    unique case (sz)
      SZ_ONE:   n = 4'd0;
      SZ_TWO:   n = 4'd1;
      SZ_FOUR:  n = 4'd4;
      SZ_EIGHT: n = 4'd8;
      default:  n = 4'd0;
    endcase
    return n;
  endfunction

  // byte number idx of a value's encoding
  function automatic logic [BYTE_W-1:0] varint_byte(input logic [TS_W-1:0] v,
                                                     input size_e sz,
                                                     input logic [IDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    logic [IDX_W-1:0]  sel;
    sel = idx - 4'd1;
    if (idx == '0) begin
      unique case (sz)
        SZ_ONE:   b = {PFX_ONE, v[5:0]};
        SZ_TWO:   b = {PFX_TWO, v[13:8]};
        SZ_FOUR:  b = TAG_FOUR;
        SZ_EIGHT: b = TAG_EIGHT;
        default:  b = TAG_EIGHT;
      endcase
    end else begin
      // payload bytes go out least significant first
      b = v[BYTE_W*sel[2:0] +: BYTE_W];
    end
    return b;
  endfunction

endpackage

FILE: rtl/core/dvte_in_if.sv
// input channel carrying one trace event per request
interface dvte_in_if import dvte_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [TS_W-1:0] timestamp;
  logic [TS_W-1:0] duration;
  logic            series_start;

  modport source (output valid, output timestamp, output duration, output series_start,
                  input ready);
  modport sink   (input valid, input timestamp, input duration, input series_start,
                  output ready);
endinterface

FILE: rtl/core/dvte_out_if.sv
// output channel carrying one encoded byte per request
interface dvte_out_if import dvte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

FILE: rtl/core/dvte_front.sv
// front end: delta against the series timestamp and length classification
module dvte_front import dvte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dvte_in_if.sink    in_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output evt_entry_t entry_o
);

  logic [TS_W-1:0] prev_ts_q, prev_ts_d;
  logic [TS_W-1:0] base_ts;
  logic [TS_W-1:0] delta;
  logic            accept;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;

  // a series start measures from zero, subtraction wraps at 64 bits
  assign base_ts = in_i.series_start ? '0 : prev_ts_q;
  assign delta   = in_i.timestamp - base_ts;

  // classified entry for the queue
  always_comb begin
    entry_o.delta    = delta;
    entry_o.duration = in_i.duration;
    entry_o.delta_sz = classify(delta);
    entry_o.dur_sz   = classify(in_i.duration);
  end

  // remember the timestamp of each accepted event
  assign prev_ts_d = accept ? in_i.timestamp : prev_ts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ts_q <= '0;
    end else begin
      prev_ts_q <= prev_ts_d;
    end
  end

endmodule

FILE: rtl/core/dvte_queue.sv
// two-entry queue between front end and serializer
module dvte_queue import dvte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  evt_entry_t push_entry_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output evt_entry_t pop_entry_o
);

  localparam logic [1:0] DEPTH = 2'd2;

  evt_entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != DEPTH);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    unique case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

FILE: rtl/core/dvte_back.sv
// serializer: walks the head entry and emits one byte per cycle while the output is not stalled
module dvte_back import dvte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  evt_entry_t entry_i,
  dvte_out_if.source out_o
);

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              last_q, last_d;
  logic              phase_q, phase_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              load;
  logic              fire;
  logic [TS_W-1:0]   cur_val;
  size_e             cur_sz;
  logic              end_of_val;

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = byte_q;
  assign out_o.last_byte = last_q;

  // output register refills when empty or being taken
  assign load = !out_valid_q || out_o.ready;
  assign fire = load && pop_valid_i;

  // phase 0 encodes the delta, phase 1 the duration
  assign cur_val    = phase_q ? entry_i.duration : entry_i.delta;
  assign cur_sz     = phase_q ? entry_i.dur_sz : entry_i.delta_sz;
  assign end_of_val = (idx_q == last_index(cur_sz));

  assign pop_ready_o = fire && phase_q && end_of_val;

  // byte walk
  always_comb begin
    idx_d       = idx_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    last_d      = last_q;
    if (load) begin
      out_valid_d = pop_valid_i;
    end
    if (fire) begin
      byte_d = varint_byte(cur_val, cur_sz, idx_q);
      last_d = phase_q && end_of_val;
      if (end_of_val) begin
        idx_d   = '0;
        phase_d = ~phase_q;
      end else begin
        idx_d = idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

`ifndef NO_ASSERTIONS
  // the byte index never runs past the end of the current value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid_i |-> (idx_q <= last_index(cur_sz)))
    else $error("byte index beyond value length");

  // an entry leaves the queue only with the final duration byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ready_o |=> (out_valid_q && last_q && !phase_q && (idx_q == '0)))
    else $error("entry released without final byte");

  // finishing the delta moves on to the duration of the same entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !phase_q && end_of_val) |=> (phase_q && (idx_q == '0) && !last_q))
    else $error("delta end did not switch to duration");

  // a stalled output register keeps the walk position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> ($stable(idx_q) && $stable(phase_q)))
    else $error("walk advanced while output stalled");
`endif

endmodule

FILE: rtl/core/delta_varint_trace_encoder.sv
// top level of the delta prefix-varint trace event encoder
//
// in_i takes one trace event per request: timestamp, duration and
// series_start. The timestamp is turned into a delta against the previous
// event of the series (zero after series_start), wrapping at 64 bits.
// out_o gives the encoded stream one byte per request: the delta, then
// the duration, each as a prefix-tagged value of 1, 2, 5 or 9 bytes;
// last_byte marks the final byte of each event.
// An event is 2 to 18 bytes long; the serializer moves one byte per cycle
// while the receiver takes them; the front end takes an event in every
// cycle while the two-entry queue has room, so events stream back to back.
// The first byte of a request is written to the queue, then to the output
// register.
// Reset clears the previous timestamp to zero and empties the queue and
// the output register.
// When the receiver stalls the output byte holds, the serializer waits,
// and once the queue fills in_i.ready drops.
module delta_varint_trace_encoder import dvte_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dvte_in_if.sink    in_i,
  dvte_out_if.source out_o
);

  logic       push_valid, push_ready;
  logic       pop_valid, pop_ready;
  evt_entry_t push_entry, pop_entry;

  // accept and classify
  dvte_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .entry_o      (push_entry)
  );

  // decoupling queue
  dvte_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // byte serializer
  dvte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .entry_i     (pop_entry),
    .out_o       (out_o)
  );

endmodule

FILE: test/dvte_byte_checker.sv
// checker that predicts the encoded byte stream of each trace event and compares it
`timescale 1ns / 100ps

module dvte_byte_checker import dvte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [TS_W-1:0]   timestamp_i,
  input  logic [TS_W-1:0]   duration_i,
  input  logic              series_start_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [BYTE_W-1:0] out_byte_i,
  input  logic              last_byte_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } enc_byte_t;

  // bytes still owed by the block, oldest first
  enc_byte_t       expected_bytes[$];
  logic [TS_W-1:0] series_prev_ts;
  int unsigned     mismatch_count;

  // append the prefix-tagged encoding of one value
  function automatic void push_value(input logic [TS_W-1:0] v, input logic closes_event);
    logic [BYTE_W-1:0] enc[$];
    size_e             sz;
    enc_byte_t         b;
    if (v <= LIMIT_ONE) begin
      sz = SZ_ONE;
    end else if (v <= LIMIT_TWO) begin
      sz = SZ_TWO;
    end else if (v <= LIMIT_FOUR) begin
      sz = SZ_FOUR;
    end else begin
      sz = SZ_EIGHT;
    end
    unique case (sz)
      SZ_ONE: begin
        enc.push_back({PFX_ONE, v[5:0]});
      end
      SZ_TWO: begin
        enc.push_back({PFX_TWO, v[13:8]});
        enc.push_back(v[7:0]);
      end
      SZ_FOUR: begin
        enc.push_back(TAG_FOUR);
        for (int i = 0; i < 4; i++) enc.push_back(v[8*i +: 8]);
      end
      default: begin
        enc.push_back(TAG_EIGHT);
        for (int i = 0; i < 8; i++) enc.push_back(v[8*i +: 8]);
      end
    endcase
    foreach (enc[i]) begin
      b.value = enc[i];
      b.last  = closes_event && (i == enc.size() - 1);
      expected_bytes.push_back(b);
    end
  endfunction

  // compare output requests, then predict from input requests
  always @(posedge clk_i or negedge rst_ni) begin
    enc_byte_t       exp_b;
    logic [TS_W-1:0] delta;
    if (!rst_ni) begin
      expected_bytes.delete();
      series_prev_ts = '0;
      mismatch_count = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte %h with last_byte %b", out_byte_i, last_byte_i);
          mismatch_count++;
        end else begin
          exp_b = expected_bytes.pop_front();
          if (out_byte_i !== exp_b.value) begin
            $error("out_byte: expected %h, actual %h", exp_b.value, out_byte_i);
            mismatch_count++;
          end
          if (last_byte_i !== exp_b.last) begin
            $error("last_byte: expected %b, actual %b", exp_b.last, last_byte_i);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (series_start_i) series_prev_ts = '0;
        delta          = timestamp_i - series_prev_ts;
        series_prev_ts = timestamp_i;
        push_value(delta, 1'b0);
        push_value(duration_i, 1'b1);
      end
      pending_o    <= expected_bytes.size();
      fail_count_o <= mismatch_count;
    end
  end

endmodule

FILE: test/delta_varint_trace_encoder_test.sv
// stimulus, handshake pacing and verdict for the delta varint trace encoder
`timescale 1ns / 100ps

module delta_varint_trace_encoder_test import dvte_pkg::*; ();

  localparam int unsigned RANDOM_EVENTS = 300;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned DRAIN_CYCLES  = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dvte_in_if  in_ch ();
  dvte_out_if out_ch ();

  int unsigned     fail_count;
  int unsigned     pending_bytes;
  logic [TS_W-1:0] series_ts;

  delta_varint_trace_encoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  dvte_byte_checker u_byte_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_ch.valid),
    .in_ready_i     (in_ch.ready),
    .timestamp_i    (in_ch.timestamp),
    .duration_i     (in_ch.duration),
    .series_start_i (in_ch.series_start),
    .out_valid_i    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .out_byte_i     (out_ch.out_byte),
    .last_byte_i    (out_ch.last_byte),
    .fail_count_o   (fail_count),
    .pending_o      (pending_bytes)
  );

  always #5 clk_i = ~clk_i;

  // gap length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // value spread over the four length classes and their borders
  function automatic logic [TS_W-1:0] pick_value();
    logic [TS_W-1:0] v;
    logic [TS_W-1:0] borders[8];
    int unsigned     cls;
    borders = '{64'd0, 64'h3F, 64'h40, 64'h3FFF, 64'h4000, 64'hFFFF_FFFF,
                64'h1_0000_0000, '1};
    cls = $urandom_range(0, 9);
    case (cls)
      0:       v = borders[$urandom_range(0, 7)];
      1, 2:    v = 64'($urandom_range(0, 63));
      3, 4:    v = 64'($urandom_range(64, 16383));
      5, 6:    v = 64'($urandom_range(16384, 32'hFFFF_FFFF));
      default: v = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)};
    endcase
    return v;
  endfunction

  // offer one event whose timestamp lies delta past the series' last one
  task automatic send_delta(input logic [TS_W-1:0] delta, input logic [TS_W-1:0] dur,
                            input logic ss, input int unsigned gap);
    logic [TS_W-1:0] ts;
    ts        = (ss ? '0 : series_ts) + delta;
    series_ts = ts;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.timestamp    <= ts;
    in_ch.duration     <= dur;
    in_ch.series_start <= ss;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // receiver pacing, with long hold-offs so the input backs up
  initial begin
    int unsigned burst_no;
    int unsigned gap;
    out_ch.ready = 1'b0;
    burst_no = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(50, 200)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_no++;
      gap = (burst_no == 25 || burst_no == 150) ? LONG_HOLD : idle_len();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  // reset, directed events, random series, drain and verdict
  initial begin
    logic [TS_W-1:0] delta;
    logic            ss;
    int unsigned     r;
    int unsigned     gap;
    in_ch.valid        = 1'b0;
    in_ch.timestamp    = '0;
    in_ch.duration     = '0;
    in_ch.series_start = 1'b0;
    series_ts          = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // series start on the very first event, then every class border
    send_delta(64'd0, 64'd0, 1'b1, idle_len());
    send_delta(64'h3F, 64'h3F, 1'b0, idle_len());
    send_delta(64'h40, 64'h40, 1'b0, idle_len());
    send_delta(64'h3FFF, 64'h3FFF, 1'b0, idle_len());
    send_delta(64'h4000, 64'h4000, 1'b0, idle_len());
    send_delta(64'hFFFF_FFFF, 64'hFFFF_FFFF, 1'b0, idle_len());
    send_delta(64'h1_0000_0000, 64'h1_0000_0000, 1'b0, idle_len());
    // all-ones timestamp and duration
    send_delta('1, '1, 1'b1, idle_len());
    // repeated timestamp gives a zero delta
    send_delta(64'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, idle_len());
    // decreasing timestamp wraps into the eight-byte form
    send_delta(64'hFFFF_FFFF_FFFF_FFFB, 64'h5555_5555_5555_5555, 1'b0, idle_len());
    // new series in the middle of the stream
    send_delta(64'd1000, 64'd1, 1'b1, idle_len());
    send_delta(64'd1, 64'd0, 1'b0, idle_len());

    // mostly nondecreasing series, some restarts, backward steps and noise
    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      r     = $urandom_range(0, 99);
      ss    = (r < 8);
      delta = pick_value();
      if (r >= 8 && r < 13) begin
        delta = -(64'($urandom_range(1, 32'hFFFF)));
      end else if (r >= 13 && r < 17) begin
        delta = {32'($urandom), 32'($urandom)};
      end
      gap = ((i % 60) < 15) ? 0 : idle_len();
      send_delta(delta, pick_value(), ss, gap);
    end
    in_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: delta_varint_trace_encoder.f
rtl/core/dvte_pkg.sv
rtl/core/dvte_in_if.sv
rtl/core/dvte_out_if.sv
rtl/core/dvte_front.sv
rtl/core/dvte_queue.sv
rtl/core/dvte_back.sv
rtl/core/delta_varint_trace_encoder.sv
test/dvte_byte_checker.sv
test/delta_varint_trace_encoder_test.sv
